FILE: design/shared_buffer_multi_queue_assert.svh
// Assertion macros shared by the shared-buffer multi-queue RTL.
// Included by the modules that check their own logic; needs no package.
`ifndef SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held
`define SBMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbmq: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define SBMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbmq: next-cycle check failed");

`else

`define SBMQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBMQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/sbmq_pkg.sv
// Shared types and constants for the shared-buffer multi-queue.
// Used by sbmq_ram and shared_buffer_multi_queue; depends on nothing.
package sbmq_pkg;

    // Fixed field widths
    localparam int DATA_W   = 32;
    localparam int QID_W    = 2;
    localparam int STATUS_W = 2;

    // Default sizing
    localparam int DEPTH_DEF  = 256;
    localparam int QUEUES_DEF = 4;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

FILE: design/sbmq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Takes its default sizes from sbmq_pkg.
module sbmq_ram
    import sbmq_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/shared_buffer_multi_queue.sv
// QUEUES first-in first-out queues sharing one store of DEPTH data slots, each queue a
// linked list of slots, with the unused slots on a free list. One beat goes in, one
// result beat comes out: status OK, FULL (push with no free slot or queue number out of
// range) or EMPTY (pop of an empty or out-of-range queue), plus the popped word. The
// accept cycle issues the link and data RAM reads (free head for a push, queue head for
// a pop); in S_EXEC, once the output register is free, the link and data RAMs are written
// back and the output register is loaded, and a new item is taken in the cycle after
// write-back. The result waits in an output register, so an item may be accepted while
// the previous result is still stalled. There is no clearing pass after reset: slots
// never handed out are tracked by a watermark, so the link RAM needs no initialization.
// Depends on sbmq_pkg, sbmq_ram and shared_buffer_multi_queue_assert.svh.
`include "shared_buffer_multi_queue_assert.svh"

module shared_buffer_multi_queue
    import sbmq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [QID_W-1:0]           i_queue_id,
    input  logic signed [DATA_W-1:0]   i_push_value,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DATA_W-1:0]   o_pop_value
);

    localparam int AW  = $clog2(DEPTH);
    localparam int LW  = $clog2(DEPTH + 1);
    localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QXW = (QIW > QID_W) ? QIW : QID_W;
    localparam logic [LW-1:0] NULL_SLOT = LW'(DEPTH);

    // Sequencer and captured beat
    t_state             r_state, n_state;
    logic               r_op;
    logic [QIW-1:0]     r_qi;
    logic               r_q_ok;
    logic [DATA_W-1:0]  r_value;

    // Queue and free-list pointers (null encoded as DEPTH)
    logic [LW-1:0]      r_head [QUEUES];
    logic [LW-1:0]      r_tail [QUEUES];
    logic [LW-1:0]      r_free_head, n_free_head;
    logic [LW-1:0]      r_fresh, n_fresh;

    // Output register
    logic               r_out_valid;
    t_status            r_status, n_status;
    logic [DATA_W-1:0]  r_pop, n_pop;

    // Input-side decode
    logic               in_accept;
    logic [QXW-1:0]     in_q_ext;
    logic               in_q_ok;
    logic [QIW-1:0]     in_qi;
    logic [LW-1:0]      in_head;

    // Execute-side values
    logic               out_free;
    logic               exec_go;
    logic [LW-1:0]      cur_head, cur_tail;
    logic               head_ok, free_ok, fresh;
    logic [LW-1:0]      fresh_next;
    logic [LW-1:0]      link_clamp;
    logic               q_we;
    logic [LW-1:0]      n_qhead, n_qtail;

    // RAM ports
    logic               link_we, data_we;
    logic [AW-1:0]      link_waddr, link_raddr, data_raddr;
    logic [LW-1:0]      link_wdata, link_rd;
    logic [DATA_W-1:0]  data_rd;

    // Input beat decode and read address selection
    always_comb begin
        in_q_ext   = QXW'(i_queue_id);
        in_q_ok    = (32'(i_queue_id) < 32'(QUEUES));
        in_qi      = in_q_ok ? in_q_ext[QIW-1:0] : '0;
        in_head    = r_head[in_qi];
        link_raddr = (i_operation == OP_POP) ? in_head[AW-1:0] : r_free_head[AW-1:0];
        data_raddr = in_head[AW-1:0];
    end

    // Sequencer: next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        in_accept  = 1'b0;
        exec_go    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                in_accept  = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                exec_go = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_operation;
            r_qi    <= in_qi;
            r_q_ok  <= in_q_ok;
            r_value <= i_push_value;
        end
    end

    // Link and data stores
    sbmq_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (in_accept),
        .i_raddr (link_raddr),
        .o_rdata (link_rd)
    );

    sbmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_free_head[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (in_accept),
        .i_raddr (data_raddr),
        .o_rdata (data_rd)
    );

    // Execute: pointer update and write-back
    always_comb begin
        cur_head   = r_head[r_qi];
        cur_tail   = r_tail[r_qi];
        head_ok    = (cur_head < NULL_SLOT);
        free_ok    = (r_free_head < NULL_SLOT);
        // free head at the watermark has never been used: its link is the next slot
        fresh      = (r_free_head == r_fresh);
        fresh_next = r_free_head + LW'(1);
        link_clamp = (link_rd < NULL_SLOT) ? link_rd : NULL_SLOT;

        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        q_we        = 1'b0;
        n_qhead     = cur_head;
        n_qtail     = cur_tail;
        link_we     = 1'b0;
        link_waddr  = cur_tail[AW-1:0];
        link_wdata  = r_free_head;
        data_we     = 1'b0;
        n_status    = ST_OK;
        n_pop       = '0;

        if (r_op == OP_PUSH) begin
            if (!r_q_ok || !free_ok) begin
                n_status = ST_FULL;
            end else begin
                n_free_head = fresh ? fresh_next : link_clamp;
                if (fresh) begin
                    n_fresh = fresh_next;
                end
                q_we    = 1'b1;
                n_qtail = r_free_head;
                if (!head_ok) begin
                    n_qhead = r_free_head;
                end else begin
                    // append behind the current tail
                    link_we    = 1'b1;
                    link_waddr = cur_tail[AW-1:0];
                    link_wdata = r_free_head;
                end
                data_we = 1'b1;
            end
        end else begin
            if (!r_q_ok || !head_ok) begin
                n_status = ST_EMPTY;
            end else begin
                // the tail's link is never written, so a one-slot queue drains by compare
                q_we        = 1'b1;
                n_qhead     = (cur_head == cur_tail) ? NULL_SLOT : link_clamp;
                link_we     = 1'b1;
                link_waddr  = cur_head[AW-1:0];
                link_wdata  = r_free_head;
                n_free_head = cur_head;
                n_pop       = data_rd;
            end
        end

        link_we = link_we & exec_go;
        data_we = data_we & exec_go;
    end

    // Free list head and never-used watermark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_fresh     <= '0;
        end else if (exec_go) begin
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
        end
    end

    // Queue heads start null
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= NULL_SLOT;
            end
        end else if (exec_go && q_we) begin
            r_head[r_qi] <= n_qhead;
        end
    end

    // Tails are only read while the head is valid
    always_ff @(posedge i_clk) begin
        if (exec_go && q_we) begin
            r_tail[r_qi] <= n_qtail;
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_status <= n_status;
            r_pop    <= n_pop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop;

    // Checks
    `SBMQ_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, in_accept, r_state == S_EXEC)
    `SBMQ_ASSERT_NXT(a_exec_loads_out, i_clk, i_rst_n, exec_go, r_out_valid)
    `SBMQ_ASSERT_NXT(a_fresh_monotonic, i_clk, i_rst_n, 1'b1, r_fresh >= $past(r_fresh))
    `SBMQ_ASSERT_IMP(a_free_below_fresh, i_clk, i_rst_n, r_free_head < NULL_SLOT, r_free_head <= r_fresh)
    `SBMQ_ASSERT_IMP(a_zero_on_fail, i_clk, i_rst_n, r_out_valid && (r_status != ST_OK), r_pop == '0)

endmodule

FILE: test/testbench.sv
// Self-checking testbench for shared_buffer_multi_queue: pushes and pops across the
// queues, predicts status and popped word from its own linked-list model of the store.
// Depends on sbmq_pkg and the shared_buffer_multi_queue RTL.
module testbench
    import sbmq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS   = DEPTH_DEF;
    localparam int QCOUNT  = QUEUES_DEF;
    localparam int NIL     = SLOTS;

    // Idling percentages per phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_HIGH = 86;
    localparam int IDLE_LOW  = 14;

    typedef struct {
        t_status             status;
        logic [DATA_W-1:0]   word;
    } t_qresult;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_operation;
    logic [QID_W-1:0]           i_queue_id;
    logic signed [DATA_W-1:0]   i_push_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [STATUS_W-1:0]        o_status;
    logic signed [DATA_W-1:0]   o_pop_value;

    // Model state: slot words, slot links, per-queue head/tail, free list head
    logic [DATA_W-1:0]  slot_word [SLOTS];
    int                 slot_next [SLOTS];
    int                 q_first   [QCOUNT];
    int                 q_last    [QCOUNT];
    int                 free_top;

    t_qresult           pending_results [$];
    int                 error_count = 0;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    shared_buffer_multi_queue #(
        .DEPTH  (SLOTS),
        .QUEUES (QCOUNT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_queue_id   (i_queue_id),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Model reset: every slot chained on the free list, all queues empty
    function automatic void queue_model_clear();
        for (int i = 0; i < SLOTS; i++) begin
            slot_word[i] = '0;
            slot_next[i] = i + 1;
        end
        slot_next[SLOTS-1] = NIL;
        for (int q = 0; q < QCOUNT; q++) begin
            q_first[q] = NIL;
            q_last[q]  = NIL;
        end
        free_top = 0;
    endfunction

    // Model update for one accepted beat; returns the expected result
    function automatic t_qresult queue_model_step(logic op, logic [QID_W-1:0] qid,
                                                  logic [DATA_W-1:0] word);
        t_qresult r;
        int       slot;
        r.status = ST_OK;
        r.word   = '0;
        if (op == OP_PUSH) begin
            if (int'(qid) >= QCOUNT || free_top == NIL) begin
                r.status = ST_FULL;
            end else begin
                slot = free_top;
                free_top = slot_next[slot];
                // empty queue: new slot becomes head; old tail is stale and unused
                if (q_first[qid] == NIL) begin
                    q_first[qid] = slot;
                end else begin
                    slot_next[q_last[qid]] = slot;
                end
                slot_next[slot] = NIL;
                q_last[qid] = slot;
                slot_word[slot] = word;
            end
        end else begin
            if (int'(qid) >= QCOUNT || q_first[qid] == NIL) begin
                r.status = ST_EMPTY;
            end else begin
                slot = q_first[qid];
                q_first[qid] = slot_next[slot];
                slot_next[slot] = free_top;
                free_top = slot;
                r.word = slot_word[slot];
            end
        end
        return r;
    endfunction

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker: compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_qresult exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, status %0d, word %h",
                         $time, o_status, o_pop_value);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, exp_r.status, o_status);
                    error_count++;
                end
                if (o_pop_value !== exp_r.word) begin
                    $display("%0t: pop_value mismatch, expected %h, got %h",
                             $time, exp_r.word, o_pop_value);
                    error_count++;
                end
            end
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Send one beat, with random idle cycles ahead of it, and record its result
    task automatic send_beat(input logic op, input logic [QID_W-1:0] qid,
                             input logic [DATA_W-1:0] word);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_queue_id   <= qid;
        i_push_value <= word;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(queue_model_step(op, qid, word));
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_random(input int push_pct);
        logic op;
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        send_beat(op, QID_W'($urandom_range(QCOUNT - 1)), DATA_W'($urandom));
    endtask

    // Extremes of the word, every queue, empty pops and refill after a drain
    task automatic test_basic_ops();
        send_beat(OP_PUSH, 2'd0, 32'h7FFF_FFFF);
        send_beat(OP_PUSH, 2'd0, 32'h8000_0000);
        send_beat(OP_PUSH, 2'd1, 32'h0000_0000);
        send_beat(OP_PUSH, 2'd2, -32'sd1);
        send_beat(OP_PUSH, 2'd3, 32'hA5A5_A5A5);
        send_beat(OP_POP,  2'd0, 32'hFFFF_FFFF);
        send_beat(OP_POP,  2'd0, 32'h0000_0000);
        send_beat(OP_POP,  2'd0, 32'h1234_5678);
        send_beat(OP_POP,  2'd1, 32'h0000_0000);
        send_beat(OP_POP,  2'd1, 32'h0000_0000);
        // queue 1 drained: stale tail must not be followed
        send_beat(OP_PUSH, 2'd1, 32'h5A5A_5A5A);
        send_beat(OP_PUSH, 2'd1, 32'h0000_0001);
        send_beat(OP_POP,  2'd1, 32'h0000_0000);
        send_beat(OP_POP,  2'd1, 32'h0000_0000);
        send_beat(OP_POP,  2'd2, 32'h0000_0000);
        send_beat(OP_POP,  2'd3, 32'h0000_0000);
        send_beat(OP_POP,  2'd3, 32'h0000_0000);
        send_beat(OP_POP,  2'd2, 32'h0000_0000);
        send_beat(OP_PUSH, 2'd0, 32'h8000_0001);
        send_beat(OP_POP,  2'd0, 32'h0000_0000);
        drop_valid();
    endtask

    // Push-heavy traffic: store fills and pushes start to report full
    task automatic test_fill_to_full(input int count);
        repeat (count) send_random(92);
        drop_valid();
    endtask

    // Pop-heavy traffic: queues drain and pops report empty
    task automatic test_drain_to_empty(input int count);
        repeat (count) send_random(8);
        drop_valid();
    endtask

    // Balanced traffic around a partly filled store
    task automatic test_random_mix(input int count);
        repeat (count) send_random(55);
        drop_valid();
    endtask

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = OP_PUSH;
        i_queue_id   = '0;
        i_push_value = '0;
        set_idling(IDLE_NONE, IDLE_NONE);
        queue_model_clear();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_fill_to_full(350);
        set_idling(IDLE_HIGH, IDLE_NONE);
        test_drain_to_empty(350);
        set_idling(IDLE_NONE, IDLE_HIGH);
        test_fill_to_full(350);
        set_idling(IDLE_LOW, IDLE_LOW);
        test_drain_to_empty(350);
        set_idling(IDLE_NONE, IDLE_NONE);
        test_random_mix(250);
        set_idling(IDLE_LOW, IDLE_LOW);
        test_random_mix(250);

        // Wait for the remaining result beats, then a short quiet tail
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/sbmq_pkg.sv
design/sbmq_ram.sv
design/shared_buffer_multi_queue.sv
test/testbench.sv
